// File: hdl/gsps_pkg.sv
package gsps_pkg;

   // field widths
   localparam int COORD_W   = 8;
   localparam int PIXEL_W   = 8;
   localparam int INV_W     = 20;
   localparam int CSR_IDX_W = 2;
   localparam int MAG_W     = COORD_W + INV_W;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int SUM_W     = SQ_W + 1;

   // q = sum >> 16, table index = q >> 8
   localparam int Q_SHIFT     = 16;
   localparam int IDX_SHIFT   = 8;
   localparam int IDX_LSB     = Q_SHIFT + IDX_SHIFT;
   localparam int IDX_FULL_W  = SUM_W - IDX_LSB;

   // exp table
   localparam int EXP_TABLE_DEPTH = 1024;
   localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);

   localparam logic [PIXEL_W-1:0] GAUSS_PEAK    = 8'd255;
   localparam logic [PIXEL_W-1:0] REPLACE_LIMIT = 8'd10;

   // pipeline depth
   localparam int NUM_STAGES = 6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INV_SIGMA_X = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INV_SIGMA_Y = 2'd3;

   // register reset values
   localparam logic [COORD_W-1:0] CENTER_RESET = 8'd128;
   localparam logic [INV_W-1:0]   INV_RESET    = 20'd6554;

   // exp(-1/256) in unsigned Q.56 from its series
   localparam logic [63:0] Q56_ONE  = 64'd1 << 56;
   localparam logic [63:0] Q56_HALF = 64'd1 << 55;
   localparam logic [63:0] EXP_T1   = Q56_ONE / 64'd256;
   localparam logic [63:0] EXP_T2   = EXP_T1 / 64'd512;
   localparam logic [63:0] EXP_T3   = EXP_T2 / 64'd768;
   localparam logic [63:0] EXP_T4   = EXP_T3 / 64'd1024;
   localparam logic [63:0] EXP_T5   = EXP_T4 / 64'd1280;
   localparam logic [63:0] EXP_T6   = EXP_T5 / 64'd1536;
   localparam logic [63:0] EXP_FACTOR =
      Q56_ONE - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4 - EXP_T5 + EXP_T6;

   typedef logic [PIXEL_W-1:0] exp_tab_type [EXP_TABLE_DEPTH];

   // each entry is round(255 * e), then e is scaled by exp(-1/256)
   function automatic exp_tab_type build_exp_tab();
      exp_tab_type  tab;
      logic [63:0]  e;
      logic [127:0] prod;
      logic [71:0]  scaled;
      e = Q56_ONE;
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
         scaled = 72'(e) * 72'(GAUSS_PEAK) + 72'(Q56_HALF);
         tab[i] = scaled[63:56];
         prod   = 128'(e) * 128'(EXP_FACTOR);
         e      = prod[119:56];
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage

// File: hdl/gaussian_spot_pixel_stamp.sv
// Gaussian spot stamp over a pixel stream.
// Input transactions on req_* carry a pixel's row, column and old gray value;
// each produces exactly one output transaction on rsp_* with the new gray value
// and a flag that is set when the gaussian value replaced the old one.
// The spot center and reciprocal spreads are written through csr_* (index,
// data, write enable, no read-back); the user must write them only while the
// stream is idle, which the block itself does not enforce. Six register stages,
// the first loaded at input acceptance: offset, two multiplier stages, sum and
// range check, exp table read, select.
// Throughput is one pixel per clock while rsp_tready is high; the 1024-entry
// exp table is a ROM with a registered read in the fifth stage.
// Synchronous active-high reset empties the pipeline and loads center 128,128
// and reciprocal spread 6554 on both axes.
// When rsp_tready is low the output holds; each stage keeps its data only
// while the stage after it is full and blocked, so bubbles are squeezed out
// and req_tready stays high until all six stages are full.
module gaussian_spot_pixel_stamp (
   input  logic                          clock,
   input  logic                          reset,
   // configuration write port
   input  logic                          csr_we,
   input  logic [gsps_pkg::CSR_IDX_W-1:0] csr_addr,
   input  logic [gsps_pkg::INV_W-1:0]    csr_wdata,
   // pixel input
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,  // pixel_row, pixel_col, old_pixel
   // pixel output
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,  // new_pixel
   output logic                          rsp_tuser   // replaced
);
   import gsps_pkg::*;

   // configuration registers
   logic [COORD_W-1:0] center_x_ff, center_x_in;
   logic [COORD_W-1:0] center_y_ff, center_y_in;
   logic [INV_W-1:0]   inv_x_ff, inv_x_in;
   logic [INV_W-1:0]   inv_y_ff, inv_y_in;

   // pipeline control
   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES:0]   load;

   // input fields
   logic [COORD_W-1:0] pixel_row, pixel_col;
   logic [PIXEL_W-1:0] old_pixel;

   // stage data
   logic [COORD_W-1:0] dist_x_ff, dist_x_in, dist_y_ff, dist_y_in;
   logic [PIXEL_W-1:0] old1_ff, old2_ff, old3_ff, old4_ff, old5_ff;
   logic [MAG_W-1:0]   mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic [SQ_W-1:0]    sq_x_ff, sq_x_in, sq_y_ff, sq_y_in;
   logic [SUM_W-1:0]   sum_in;
   logic [IDX_FULL_W-1:0] idx_full;
   logic [EXP_IDX_W-1:0]  idx_ff, idx_in;
   logic               far4_ff, far4_in, far5_ff;
   logic [PIXEL_W-1:0] exp_ff;
   logic [PIXEL_W-1:0] new_pixel_ff, new_pixel_in;
   logic               replaced_ff, replaced_in;

   assign pixel_row = req_tdata[7:0];
   assign pixel_col = req_tdata[15:8];
   assign old_pixel = req_tdata[23:16];

   // configuration writes
   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      inv_x_in    = inv_x_ff;
      inv_y_in    = inv_y_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_CENTER_X:    center_x_in = csr_wdata[COORD_W-1:0];
            REG_CENTER_Y:    center_y_in = csr_wdata[COORD_W-1:0];
            REG_INV_SIGMA_X: inv_x_in    = csr_wdata;
            REG_INV_SIGMA_Y: inv_y_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= CENTER_RESET;
         center_y_ff <= CENTER_RESET;
         inv_x_ff    <= INV_RESET;
         inv_y_ff    <= INV_RESET;
      end else begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         inv_x_ff    <= inv_x_in;
         inv_y_ff    <= inv_y_in;
      end
   end

   // stage load enables, a stage takes new data when empty or draining
   always_comb begin
      load[NUM_STAGES] = rsp_tready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in[0] = load[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign req_tready = load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: absolute offsets from the center
   assign dist_x_in = (pixel_col >= center_x_ff) ? pixel_col - center_x_ff
                                                 : center_x_ff - pixel_col;
   assign dist_y_in = (pixel_row >= center_y_ff) ? pixel_row - center_y_ff
                                                 : center_y_ff - pixel_row;

   // stage 2: scale by reciprocal spread
   assign mag_x_in = MAG_W'(dist_x_ff) * MAG_W'(inv_x_ff);
   assign mag_y_in = MAG_W'(dist_y_ff) * MAG_W'(inv_y_ff);

   // stage 3: squares
   assign sq_x_in = SQ_W'(mag_x_ff) * SQ_W'(mag_x_ff);
   assign sq_y_in = SQ_W'(mag_y_ff) * SQ_W'(mag_y_ff);

   // stage 4: sum, table index and far-field check
   assign sum_in   = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff);
   assign idx_full = sum_in[SUM_W-1:IDX_LSB];
   assign far4_in  = idx_full >= IDX_FULL_W'(EXP_TABLE_DEPTH);
   assign idx_in   = idx_full[EXP_IDX_W-1:0];

   // stage 6: replace when the gaussian value is above the limit
   always_comb begin
      if (!far5_ff && (exp_ff > REPLACE_LIMIT)) begin
         new_pixel_in = exp_ff;
         replaced_in  = 1'b1;
      end else begin
         new_pixel_in = old5_ff;
         replaced_in  = 1'b0;
      end
   end

   // stage data registers
   always_ff @(posedge clock) begin
      if (load[0]) begin
         dist_x_ff <= dist_x_in;
         dist_y_ff <= dist_y_in;
         old1_ff   <= old_pixel;
      end
      if (load[1]) begin
         mag_x_ff <= mag_x_in;
         mag_y_ff <= mag_y_in;
         old2_ff  <= old1_ff;
      end
      if (load[2]) begin
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
         old3_ff <= old2_ff;
      end
      if (load[3]) begin
         idx_ff  <= idx_in;
         far4_ff <= far4_in;
         old4_ff <= old3_ff;
      end
      // exp table rom, registered read
      if (load[4]) begin
         exp_ff  <= EXP_TAB[idx_ff];
         far5_ff <= far4_ff;
         old5_ff <= old4_ff;
      end
      if (load[5]) begin
         new_pixel_ff <= new_pixel_in;
         replaced_ff  <= replaced_in;
      end
   end

   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = new_pixel_ff;
   assign rsp_tuser  = replaced_ff;

   // a replaced pixel always carries a value above the limit
   a_replaced_above_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata > REPLACE_LIMIT)
      else $error("replaced pixel not above limit");

   // an accepted input fills the first stage
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted input lost in first stage");

   // a pixel past the table range is never replaced
   a_far_kept: assert property (@(posedge clock) disable iff (reset)
      load[5] && valid_ff[4] && far5_ff |=> rsp_tvalid && !rsp_tuser)
      else $error("far pixel was replaced");

endmodule

// File: verif/gaussian_spot_pixel_stamp_test.sv
`timescale 1ns / 1ps

module gaussian_spot_pixel_stamp_test;

   import gsps_pkg::*;

   typedef struct packed {
      logic [PIXEL_W-1:0] new_pixel;
      logic               replaced;
   } stamp_result_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIXEL_W-1:0] old;
      logic               known;
      stamp_result_type   want;
   } stamp_case_type;

   localparam int NUM_CASES = 17;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_addr;
   logic [INV_W-1:0]     csr_wdata;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [23:0]          req_tdata;   // pixel_row, pixel_col, old_pixel
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [7:0]           rsp_tdata;   // new_pixel
   logic                 rsp_tuser;   // replaced

   // shadow of the spot registers
   logic [COORD_W-1:0] spot_cx;
   logic [COORD_W-1:0] spot_cy;
   logic [INV_W-1:0]   spot_inv_x;
   logic [INV_W-1:0]   spot_inv_y;

   logic [PIXEL_W-1:0] exp_levels [EXP_TABLE_DEPTH];
   stamp_result_type   pending_stamps [$];
   stamp_result_type   oldest_stamp;
   stamp_case_type     pixel_cases [NUM_CASES];

   bit gaps_on;
   bit held_off;
   int pixels_sent;
   int stamps_seen;
   int stamps_replaced;
   int spot_settings;
   int errors;

   gaussian_spot_pixel_stamp dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // 255 * exp(-i/256) rounded, stepped in unsigned Q.56
   function automatic void fill_exp_levels();
      logic [63:0]  term;
      logic [63:0]  step;
      logic [63:0]  e;
      logic [127:0] prod;
      logic [71:0]  scaled;
      term = 64'd1 << 56;
      step = term;
      e    = term;
      // series for exp(-1/256)
      for (int n = 1; n < 40; n++) begin
         term = term / (64'd256 * 64'(n));
         if (term == 64'd0) break;
         if (n % 2 == 1) step = step - term;
         else step = step + term;
      end
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
         scaled        = 72'(e) * 72'd255 + 72'(64'd1 << 55);
         exp_levels[i] = scaled[63:56];
         prod          = 128'(e) * 128'(step);
         e             = prod[119:56];
      end
   endfunction

   // expected output pixel for the current spot
   function automatic stamp_result_type gaussian_stamp(input logic [7:0] row,
                                                       input logic [7:0] col,
                                                       input logic [7:0] old);
      logic [7:0]       dx;
      logic [7:0]       dy;
      logic [27:0]      ax;
      logic [27:0]      ay;
      logic [56:0]      energy;
      logic [32:0]      level_idx;
      logic [7:0]       level;
      stamp_result_type res;
      dx     = (col >= spot_cx) ? col - spot_cx : spot_cx - col;
      dy     = (row >= spot_cy) ? row - spot_cy : spot_cy - row;
      ax     = 28'(dx) * 28'(spot_inv_x);
      ay     = 28'(dy) * 28'(spot_inv_y);
      energy = 57'(ax) * 57'(ax) + 57'(ay) * 57'(ay);
      // q = energy >> 16, table steps are 1/256 of q
      level_idx = 33'(energy >> 24);
      level = (level_idx < EXP_TABLE_DEPTH) ? exp_levels[level_idx[EXP_IDX_W-1:0]] : 8'd0;
      if (level > REPLACE_LIMIT) res = '{level, 1'b1};
      else res = '{old, 1'b0};
      return res;
   endfunction

   // pixel distance at which the spot fades out (q reaches 262144, the end of the table)
   function automatic int reach_of(input logic [INV_W-1:0] inv);
      int r;
      r = (inv == '0) ? 255 : int'(131072 / inv) + 2;
      if (r > 255) r = 255;
      return r;
   endfunction

   function automatic logic [7:0] near_coord(input logic [7:0] center, input int reach);
      int c;
      c = int'(center) + int'($urandom_range(2 * reach)) - reach;
      if (c < 0) c = 0;
      if (c > 255) c = 255;
      return 8'(c);
   endfunction

   function automatic logic [INV_W-1:0] pick_inv();
      if ($urandom_range(4) == 0) return INV_W'($urandom_range(1, 1048575));
      return INV_W'($urandom_range(600, 30000));
   endfunction

   // one input transaction, expectation queued at acceptance
   task automatic offer_pixel(input logic [7:0] row, input logic [7:0] col,
                              input logic [7:0] old, input logic known,
                              input stamp_result_type want);
      while (gaps_on && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {old, col, row};
      do @(posedge clock); while (!req_tready);
      pending_stamps.push_back(known ? want : gaussian_stamp(row, col, old));
      pixels_sent++;
   endtask

   task automatic drain_stamps();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_stamps.size() != 0);
   endtask

   // write all four spot registers, center words carry junk above bit 7
   task automatic load_spot(input logic [7:0] cx, input logic [7:0] cy,
                            input logic [INV_W-1:0] isx, input logic [INV_W-1:0] isy);
      logic [INV_W-1:0]     words [4];
      logic [CSR_IDX_W-1:0] slots [4];
      words = '{{12'($urandom), cx}, {12'($urandom), cy}, isx, isy};
      slots = '{REG_CENTER_X, REG_CENTER_Y, REG_INV_SIGMA_X, REG_INV_SIGMA_Y};
      for (int k = 0; k < 4; k++) begin
         csr_we    <= 1'b1;
         csr_addr  <= slots[k];
         csr_wdata <= words[k];
         @(posedge clock);
      end
      csr_we     <= 1'b0;
      spot_cx    = cx;
      spot_cy    = cy;
      spot_inv_x = isx;
      spot_inv_y = isy;
      spot_settings++;
   endtask

   // one spot setting: mostly pixels around the spot, some anywhere
   task automatic run_spot(input logic [7:0] cx, input logic [7:0] cy,
                           input logic [INV_W-1:0] isx, input logic [INV_W-1:0] isy,
                           input int count, input bit pause_midway);
      logic [7:0] row;
      logic [7:0] col;
      drain_stamps();
      load_spot(cx, cy, isx, isy);
      for (int k = 0; k < count; k++) begin
         if (pause_midway && k == count / 2) drain_stamps();
         if ($urandom_range(3) != 0) begin
            row = near_coord(cy, reach_of(isy));
            col = near_coord(cx, reach_of(isx));
         end else begin
            row = 8'($urandom_range(255));
            col = 8'($urandom_range(255));
         end
         offer_pixel(row, col, 8'($urandom_range(255)), 1'b0, '0);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_stamps.size() == 0) begin
            $error("result transaction with nothing expected: new_pixel %0d replaced %0d",
                   rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            oldest_stamp = pending_stamps.pop_front();
            if (rsp_tdata !== oldest_stamp.new_pixel) begin
               $error("new_pixel mismatch: expected %0d, actual %0d",
                      oldest_stamp.new_pixel, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== oldest_stamp.replaced) begin
               $error("replaced mismatch: expected %0d, actual %0d",
                      oldest_stamp.replaced, rsp_tuser);
               errors++;
            end
         end
         if (rsp_tuser === 1'b1) stamps_replaced++;
         stamps_seen++;
      end
   end

   // result side back-pressure, one long hold-off to fill the pipeline
   initial begin
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held_off && stamps_seen >= 150) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (60) @(posedge clock);
         end
         rsp_tready <= gaps_on ? ($urandom_range(99) >= 8) : 1'b1;
         @(posedge clock);
      end
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("FAIL gaussian_spot_pixel_stamp");
      $finish;
   end

   initial begin
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      reset      <= 1'b1;
      gaps_on    = 1'b1;
      spot_cx    = CENTER_RESET;
      spot_cy    = CENTER_RESET;
      spot_inv_x = INV_RESET;
      spot_inv_y = INV_RESET;
      fill_exp_levels();

      // reset spot: center 128,128, spread about 0.1 per pixel
      pixel_cases = '{
         '{8'd128, 8'd128, 8'd0,   1'b1, '{8'd255, 1'b1}},   // dead center
         '{8'd128, 8'd128, 8'd255, 1'b1, '{8'd255, 1'b1}},
         '{8'd0,   8'd0,   8'd77,  1'b1, '{8'd77,  1'b0}},   // far corner
         '{8'd255, 8'd255, 8'd0,   1'b1, '{8'd0,   1'b0}},
         '{8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 1'b0}},
         '{8'd0,   8'd255, 8'd170, 1'b1, '{8'd170, 1'b0}},
         '{8'd128, 8'd0,   8'd85,  1'b1, '{8'd85,  1'b0}},
         '{8'd128, 8'd145, 8'd200, 1'b0, '0},   // just above the replace limit
         '{8'd128, 8'd146, 8'd3,   1'b0, '0},   // just at it, so kept
         '{8'd128, 8'd147, 8'd60,  1'b0, '0},
         '{8'd128, 8'd148, 8'd99,  1'b0, '0},   // first index past the table
         '{8'd145, 8'd128, 8'd1,   1'b0, '0},
         '{8'd146, 8'd128, 8'd250, 1'b0, '0},
         '{8'd111, 8'd128, 8'd11,  1'b0, '0},
         '{8'd129, 8'd129, 8'd0,   1'b0, '0},
         '{8'd140, 8'd135, 8'h5A,  1'b0, '0},
         '{8'd127, 8'd128, 8'hA5,  1'b0, '0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed pixels under the reset spot
      for (int i = 0; i < NUM_CASES; i++)
         offer_pixel(pixel_cases[i].row, pixel_cases[i].col, pixel_cases[i].old,
                     pixel_cases[i].known, pixel_cases[i].want);

      // register extremes: needle spot, flat spot, zero reciprocal
      run_spot(8'd0, 8'd255, 20'hFFFFF, 20'hFFFFF, 40, 1'b0);
      run_spot(8'd255, 8'd0, 20'd1, 20'd1, 40, 1'b0);
      run_spot(8'($urandom_range(255)), 8'($urandom_range(255)), 20'd0, 20'd0, 40, 1'b0);

      // random spots, one setting without any idling, one with a full drain midway
      for (int p = 0; p < 7; p++) begin
         gaps_on = (p != 3);
         run_spot(8'($urandom_range(255)), 8'($urandom_range(255)), pick_inv(), pick_inv(),
                  90, p == 5);
      end
      gaps_on = 1'b1;
      req_tvalid <= 1'b0;

      // wait out the pipeline
      for (int t = 0; t < 5000 && pending_stamps.size() != 0; t++) @(posedge clock);
      repeat (2 * NUM_STAGES) @(posedge clock);
      if (pending_stamps.size() != 0) begin
         $error("%0d expected result transactions never arrived", pending_stamps.size());
         errors++;
      end

      $display("stamped %0d pixels under %0d spot settings (%0d register writes), with",
               pixels_sent, spot_settings + 1, 4 * spot_settings);
      $display("%0d taking the gaussian value and %0d keeping the old gray value",
               stamps_replaced, stamps_seen - stamps_replaced);
      if (errors == 0) begin
         $display("PASS gaussian_spot_pixel_stamp");
      end else begin
         $display("FAIL gaussian_spot_pixel_stamp");
      end
      $finish;
   end

endmodule
